FILE: hw/rtl/rpr_pkg.sv
package rpr_pkg;

    localparam int DATA_W      = 16;
    localparam int FRAC_BITS   = 14;
    localparam int POS_W       = 11;
    localparam int PAIR_W      = 6;
    localparam int ADDR_W      = POS_W + PAIR_W;
    localparam int TABLE_DEPTH = 1 << ADDR_W;
    localparam int POSCFG_W    = 12;
    localparam int PAIRCFG_W   = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int ACC_W       = PROD_W + 1;
    localparam int QUOT_W      = ACC_W - FRAC_BITS;

    localparam logic [POSCFG_W-1:0]  POSITIONS_RESET = POSCFG_W'(2048);
    localparam logic [PAIRCFG_W-1:0] PAIRS_RESET     = PAIRCFG_W'(64);

    localparam logic [CFG_IDX_W-1:0] CFG_POSITIONS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIRS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKWARD  = 2'd2;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_ROTATE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    typedef struct packed {
        logic                     req_type;
        logic [POS_W-1:0]         position;
        logic [PAIR_W-1:0]        pair_index;
        logic signed [DATA_W-1:0] first_elem;
        logic signed [DATA_W-1:0] second_elem;
        logic signed [DATA_W-1:0] cos_entry;
        logic signed [DATA_W-1:0] sin_entry;
    } t_rot_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_first;
        logic signed [DATA_W-1:0] out_second;
        t_status                  status;
    } t_rot_res;

    typedef struct packed {
        logic valid;
        logic rotate;
        logic range_err;
    } t_stage_ctl;

endpackage

FILE: hw/rtl/rpr_rotate_dp.sv
module rpr_rotate_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rpr_pkg::t_stage_ctl              i_ctl,
    input  logic signed [rpr_pkg::DATA_W-1:0] i_first,
    input  logic signed [rpr_pkg::DATA_W-1:0] i_second,
    input  logic signed [rpr_pkg::DATA_W-1:0] i_cos,
    input  logic signed [rpr_pkg::DATA_W-1:0] i_sin,
    input  logic                             i_backward,
    output logic                             o_valid,
    output rpr_pkg::t_rot_res                o_res
);
    import rpr_pkg::*;

    t_stage_ctl               r_ctl;
    logic signed [PROD_W-1:0] r_fc, r_ss, r_sc, r_fs;
    logic                     r_valid;
    t_rot_res                 r_res;

    logic signed [ACC_W-1:0]  acc1, acc2;
    logic signed [QUOT_W-1:0] q1, q2;
    logic signed [DATA_W-1:0] s1, s2;
    logic                     sat1, sat2;
    t_rot_res                 n_res;

    localparam logic signed [QUOT_W-1:0] HI = QUOT_W'((1 << (DATA_W - 1)) - 1);
    localparam logic signed [QUOT_W-1:0] LO = -QUOT_W'(1 << (DATA_W - 1));
    localparam logic signed [ACC_W-1:0]  HALF = ACC_W'(1 << (FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_fc <= PROD_W'(i_first) * PROD_W'(i_cos);
        r_ss <= PROD_W'(i_second) * PROD_W'(i_sin);
        r_sc <= PROD_W'(i_second) * PROD_W'(i_cos);
        r_fs <= PROD_W'(i_first) * PROD_W'(i_sin);
    end

    always_comb begin
        if (i_backward) begin
            acc1 = ACC_W'(r_fc) + ACC_W'(r_ss) + HALF;
            acc2 = ACC_W'(r_sc) - ACC_W'(r_fs) + HALF;
        end else begin
            acc1 = ACC_W'(r_fc) - ACC_W'(r_ss) + HALF;
            acc2 = ACC_W'(r_sc) + ACC_W'(r_fs) + HALF;
        end
        q1 = QUOT_W'(acc1 >>> FRAC_BITS);
        q2 = QUOT_W'(acc2 >>> FRAC_BITS);
        sat1 = (q1 > HI) || (q1 < LO);
        sat2 = (q2 > HI) || (q2 < LO);
        s1 = (q1 > HI) ? DATA_W'(HI) : ((q1 < LO) ? DATA_W'(LO) : DATA_W'(q1));
        s2 = (q2 > HI) ? DATA_W'(HI) : ((q2 < LO) ? DATA_W'(LO) : DATA_W'(q2));

        n_res = '0;
        if (r_ctl.range_err) begin
            n_res.status = ST_RANGE;
        end else if (r_ctl.rotate) begin
            n_res.out_first  = s1;
            n_res.out_second = s2;
            n_res.status     = (sat1 || sat2) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_ctl.valid;
        end
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: hw/rtl/rotary_position_rotate_core.sv
// A transaction passes through the input and table-read registers, the product registers
// and the result registers in turn; loads and errored transactions take the same path.
// Throughput: one transaction per cycle while busy is low; the single-port table memory
// is read even with no transaction and is written only by an accepted in-range load.
// Reset is synchronous; busy is high while in reset, and the tables are not cleared.
module rotary_position_rotate_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  rpr_pkg::t_rot_req                    i_req,
    output logic                                 o_result_valid,
    output rpr_pkg::t_rot_res                    o_result,
    input  logic                                 i_cfg_we,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [rpr_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import rpr_pkg::*;

    logic [POSCFG_W-1:0]      r_positions;
    logic [PAIRCFG_W-1:0]     r_pairs;
    logic                     r_backward;
    logic                     r_busy;

    logic [2*DATA_W-1:0]      r_mem [TABLE_DEPTH];
    logic [2*DATA_W-1:0]      r_rd_data;

    t_stage_ctl               r_ctl;
    t_stage_ctl               n_ctl;
    logic signed [DATA_W-1:0] r_first, r_second;

    logic                     accept;
    logic                     range_err;
    logic [ADDR_W-1:0]        addr;
    logic                     wr_en;

    assign accept    = start && !r_busy;
    assign range_err = ({1'b0, i_req.position} >= r_positions) ||
                       ({1'b0, i_req.pair_index} >= r_pairs);
    assign addr      = {i_req.position, i_req.pair_index};
    assign wr_en     = accept && !range_err && (i_req.req_type == REQ_LOAD);

    always_comb begin
        n_ctl.valid     = accept;
        n_ctl.rotate    = accept && (i_req.req_type == REQ_ROTATE);
        n_ctl.range_err = accept && range_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_positions <= POSITIONS_RESET;
            r_pairs     <= PAIRS_RESET;
            r_backward  <= 1'b0;
            r_busy      <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POSITIONS: r_positions <= i_cfg_data[POSCFG_W-1:0];
                    CFG_PAIRS:     r_pairs     <= i_cfg_data[PAIRCFG_W-1:0];
                    CFG_BACKWARD:  r_backward  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[addr] <= {i_req.cos_entry, i_req.sin_entry};
        end
        r_rd_data <= r_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
        r_first  <= i_req.first_elem;
        r_second <= i_req.second_elem;
    end

    rpr_rotate_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (r_ctl),
        .i_first    (r_first),
        .i_second   (r_second),
        .i_cos      (r_rd_data[2*DATA_W-1:DATA_W]),
        .i_sin      (r_rd_data[DATA_W-1:0]),
        .i_backward (r_backward),
        .o_valid    (o_result_valid),
        .o_res      (o_result)
    );

    assign busy = r_busy;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_result_valid)
        else $error("result strobe missing two cycles after a transaction");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, 3))
        else $error("result strobe without a matching transaction");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status == ST_RANGE) |->
        (o_result.out_first == '0 && o_result.out_second == '0))
        else $error("out-of-range result carries non-zero data");

    a_no_write_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && range_err) |-> !wr_en)
        else $error("table written by an out-of-range transaction");

endmodule
